// ===== rtl/glpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glpt_pkg: lease port table shared definitions
// Widths, operation and status codes, command/status structs.
// ----------------------------------------------------------------------------
package glpt_pkg;

  localparam int unsigned PORTS      = 4;
  localparam int unsigned KIND_COUNT = 4;
  localparam int unsigned PW         = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned N_STATS    = 5;

  localparam logic [2:0] OP_CLAIM      = 3'd0;
  localparam logic [2:0] OP_CLAIM_FREE = 3'd1;
  localparam logic [2:0] OP_PUBLISH    = 3'd2;
  localparam logic [2:0] OP_RELEASE    = 3'd3;
  localparam logic [2:0] OP_READ_SAMP  = 3'd4;
  localparam logic [2:0] OP_READ_LEASE = 3'd5;
  localparam logic [2:0] OP_READ_CNT   = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REJECT  = 3'd1;
  localparam logic [2:0] ST_STALE   = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_BADPORT = 3'd4;

  localparam logic [2:0] CNT_CLAIMS   = 3'd0;
  localparam logic [2:0] CNT_RELEASES = 3'd1;
  localparam logic [2:0] CNT_REJECTED = 3'd2;
  localparam logic [2:0] CNT_STALE    = 3'd3;
  localparam logic [2:0] CNT_INVALID  = 3'd4;

  localparam logic [7:0] STICK_LIMIT_RST = 8'd80;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  port;
    logic [7:0]  kind;
    logic [63:0] owner;
    logic [31:0] generation;
    logic [15:0] buttons;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic        present;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [7:0]  lease_port;
    logic [7:0]  lease_kind;
    logic [31:0] lease_generation;
    logic [63:0] lease_owner;
    logic [15:0] sample_buttons;
    logic [7:0]  sample_x;
    logic [7:0]  sample_y;
    logic        sample_present;
    logic [31:0] counter_value;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic         load;     // capture request
    logic         scan;     // examine one search candidate
    logic         execute;  // perform operation
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found;     // free port found / search resolved
    logic is_search;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/glpt_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glpt_req_if: request channel
// Valid/ready channel carrying one operation.
// ----------------------------------------------------------------------------
interface glpt_req_if;
  import glpt_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/glpt_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glpt_rsp_if: response channel
// Valid/ready channel carrying one result.
// ----------------------------------------------------------------------------
interface glpt_rsp_if;
  import glpt_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/generation_lease_port_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generation_lease_port_table: generation-tagged port lease table
// Top level joining the sequencer and the lease datapath.
// ----------------------------------------------------------------------------
// Each operation passes through load, resolve and execute; claim-first-free
// also has the round-robin scan step over each occupied port, up to PORTS
// ports. One operation is in flight at a time; the result waits in an
// output register and the next request is taken as soon as the sequencer
// returns to idle. stick_limit resets to 80.
module generation_lease_port_table (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  glpt_req_if.sink    req,
  glpt_rsp_if.source  rsp,
  input  wire logic   cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);
  import glpt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  glpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  glpt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req.payload),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp.payload)
  );

endmodule

`default_nettype wire

// ===== rtl/glpt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glpt_ctrl: sequencer
// Load, optional round-robin scan (one port a cycle), execute, deliver.
// ----------------------------------------------------------------------------
module glpt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output glpt_pkg::cmd_t       cmd_o,
  input  wire glpt_pkg::sts_t  sts_i
);
  import glpt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [PW:0] cnt_q, cnt_d;
  logic        ov_q, ov_d;

  // output slot frees when it is taken this cycle
  logic slot_free;
  assign slot_free   = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
          cnt_d      = '0;
        end
      end
      S_SCAN: begin
        if (!sts_i.is_search || sts_i.found || cnt_q == (PW+1)'(PORTS)) begin
          state_d = S_EXEC;
        end else begin
          cmd_o.scan = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.execute = 1'b1;
          ov_d          = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/glpt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glpt_datapath: lease table, counters and result register
// Holds slots, generation counter and statistics; executes one operation.
// ----------------------------------------------------------------------------
module glpt_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire glpt_pkg::req_t  req_i,
  input  wire logic            cfg_we_i,
  input  wire logic [6:0]      cfg_wdata_i,
  input  wire glpt_pkg::cmd_t  cmd_i,
  output glpt_pkg::sts_t       sts_o,
  output glpt_pkg::rsp_t       rsp_o
);
  import glpt_pkg::*;

  logic [6:0]  lim_q;
  req_t        req_q;
  logic [PW-1:0] cand_q;
  logic        found_q;

  logic [PORTS-1:0] taken_q;
  logic [7:0]  kind_q  [PORTS];
  logic [31:0] gen_q   [PORTS];
  logic [63:0] owner_q [PORTS];
  logic [32:0] samp_q  [PORTS];
  logic [31:0] next_gen_q;
  logic [31:0] stat_q  [N_STATS];
  rsp_t        rsp_q;

  logic is_search;
  assign is_search   = (req_q.operation == OP_CLAIM_FREE) &&
                       (req_q.port < 8'(PORTS));
  assign sts_o.is_search = is_search;
  assign sts_o.found     = found_q;
  assign rsp_o           = rsp_q;

  // next candidate, wrapping
  logic [PW-1:0] cand_nx;
  always_comb begin
    if ({1'b0, cand_q} == (PW+1)'(PORTS - 1)) cand_nx = '0;
    else cand_nx = cand_q + 1'b1;
  end

  // execution decode
  logic        in_range, kind_ok, claim_ok, hit, sticks_ok;
  logic [PW-1:0] p;
  logic [7:0]  xs, ys;
  logic signed [8:0] x9, y9, l9;
  rsp_t        r;
  logic        do_alloc, do_pub, do_rel, inv_samp;
  logic [4:0]  bump;
  logic [32:0] new_samp;
  logic [31:0] gen_use;

  always_comb begin
    xs = req_q.stick_x;
    ys = req_q.stick_y;
    x9 = $signed({xs[7], xs});
    y9 = $signed({ys[7], ys});
    l9 = $signed({2'b00, lim_q});
    sticks_ok = (x9 >= -l9) && (x9 <= l9) && (y9 >= -l9) && (y9 <= l9);
    p = (req_q.operation == OP_CLAIM_FREE) ? cand_q : req_q.port[PW-1:0];
    in_range = (req_q.operation == OP_CLAIM_FREE) ? found_q :
               (req_q.port < 8'(PORTS));
    kind_ok = (req_q.kind >= 8'd1) && (req_q.kind < 8'(KIND_COUNT));
    claim_ok = in_range && kind_ok && (req_q.owner != '0);
    hit = in_range && taken_q[p] && kind_q[p] == req_q.kind &&
          gen_q[p] == req_q.generation && owner_q[p] == req_q.owner;
    gen_use = (next_gen_q == '0) ? 32'd1 : next_gen_q;
    new_samp = req_q.present ? {1'b1, ys, xs, req_q.buttons} : '0;
    r = '0;
    do_alloc = 1'b0;
    do_pub   = 1'b0;
    do_rel   = 1'b0;
    inv_samp = 1'b0;
    bump     = '0;
    case (req_q.operation)
      OP_CLAIM, OP_CLAIM_FREE: begin
        if (req_q.operation == OP_CLAIM_FREE && req_q.port >= 8'(PORTS)) begin
          r.status = ST_BADPORT;
        end else if (!claim_ok) begin
          bump[CNT_REJECTED] = 1'b1;
          r.status = ST_REJECT;
        end else if (taken_q[p]) begin
          if (kind_q[p] == req_q.kind && owner_q[p] == req_q.owner) begin
            r.ok = 1'b1;
            r.lease_port = 8'(p);
            r.lease_kind = kind_q[p];
            r.lease_generation = gen_q[p];
            r.lease_owner = owner_q[p];
          end else begin
            bump[CNT_REJECTED] = 1'b1;
            r.status = ST_REJECT;
          end
        end else begin
          do_alloc = 1'b1;
          bump[CNT_CLAIMS] = 1'b1;
          r.ok = 1'b1;
          r.lease_port = 8'(p);
          r.lease_kind = req_q.kind;
          r.lease_generation = gen_use;
          r.lease_owner = req_q.owner;
        end
      end
      OP_PUBLISH: begin
        if (!hit) begin
          bump[CNT_STALE] = 1'b1;
          r.status = ST_STALE;
        end else if (!sticks_ok) begin
          bump[CNT_INVALID] = 1'b1;
          inv_samp = 1'b1;
          r.status = ST_INVALID;
        end else begin
          do_pub = 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!hit) begin
          bump[CNT_STALE] = 1'b1;
          r.status = ST_STALE;
        end else begin
          do_rel = 1'b1;
          bump[CNT_RELEASES] = 1'b1;
          r.ok = 1'b1;
        end
      end
      OP_READ_SAMP: begin
        if (!in_range || !taken_q[p]) begin
          r.status = ST_BADPORT;
        end else begin
          r.ok = 1'b1;
          r.sample_buttons = samp_q[p][15:0];
          r.sample_x = samp_q[p][23:16];
          r.sample_y = samp_q[p][31:24];
          r.sample_present = samp_q[p][32];
        end
      end
      OP_READ_LEASE: begin
        if (!in_range || !taken_q[p]) begin
          r.status = ST_BADPORT;
        end else begin
          r.ok = 1'b1;
          r.lease_port = 8'(p);
          r.lease_kind = kind_q[p];
          r.lease_generation = gen_q[p];
          r.lease_owner = owner_q[p];
        end
      end
      OP_READ_CNT: begin
        if (req_q.port >= 8'(N_STATS)) begin
          r.status = ST_BADPORT;
        end else begin
          r.ok = 1'b1;
          r.counter_value = stat_q[req_q.port[2:0]];
        end
      end
      default: r.status = ST_BADPORT;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.execute) rsp_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q      <= 7'(STICK_LIMIT_RST);
      cand_q     <= '0;
      found_q    <= 1'b0;
      taken_q    <= '0;
      next_gen_q <= 32'd1;
      for (int i = 0; i < PORTS; i++) begin
        kind_q[i]  <= '0;
        gen_q[i]   <= '0;
        owner_q[i] <= '0;
        samp_q[i]  <= '0;
      end
      for (int i = 0; i < N_STATS; i++) stat_q[i] <= '0;
    end else begin
      if (cfg_we_i) lim_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        cand_q  <= req_i.port[PW-1:0];
        found_q <= (req_i.port < 8'(PORTS)) && !taken_q[req_i.port[PW-1:0]];
      end
      if (cmd_i.scan) begin
        cand_q  <= cand_nx;
        found_q <= !taken_q[cand_nx];
      end
      if (cmd_i.execute) begin
        if (do_alloc) begin
          taken_q[p] <= 1'b1;
          kind_q[p]  <= req_q.kind;
          gen_q[p]   <= gen_use;
          owner_q[p] <= req_q.owner;
          samp_q[p]  <= {1'b1, 32'd0};
          next_gen_q <= gen_use + 32'd1;
        end
        if (do_pub) samp_q[p] <= new_samp;
        if (inv_samp) samp_q[p] <= {1'b1, 32'd0};
        if (do_rel) begin
          taken_q[p] <= 1'b0;
          kind_q[p]  <= '0;
          gen_q[p]   <= '0;
          owner_q[p] <= '0;
          samp_q[p]  <= '0;
        end
        for (int i = 0; i < N_STATS; i++) begin
          if (bump[i] && stat_q[i] != '1) stat_q[i] <= stat_q[i] + 32'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_generation_lease_port_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_generation_lease_port_table: lease port table testbench
// Drives directed and random lease operations through the request channel,
// predicts every result from a behavioural copy of the table, and compares
// each response transfer field by field. Stick limit is changed while idle.
// ----------------------------------------------------------------------------
module tb_generation_lease_port_table;
  import glpt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = 7'd0;

  glpt_req_if req ();
  glpt_rsp_if rsp ();

  generation_lease_port_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // predicted table state
  logic        tbl_taken [PORTS];
  logic [7:0]  tbl_kind  [PORTS];
  logic [31:0] tbl_gen   [PORTS];
  logic [63:0] tbl_owner [PORTS];
  logic [32:0] tbl_sample[PORTS];
  logic [31:0] gen_next;
  logic [31:0] stats[N_STATS];
  logic [6:0]  limit_pred;

  // generation-time copy of the lease state, used only to form live leases
  logic        tbl_shadow_taken[PORTS];
  logic [7:0]  tbl_shadow_kind [PORTS];
  logic [31:0] tbl_shadow_gen  [PORTS];
  logic [63:0] tbl_shadow_owner[PORTS];

  req_t pending_ops[$];
  rsp_t expected_rsps[$];
  int   n_errors = 0;
  bit   quiet = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    n_errors++;
  endtask

  function automatic void bump(input logic [2:0] idx);
    if (stats[idx] != 32'hFFFF_FFFF) stats[idx] = stats[idx] + 1;
  endfunction

  function automatic void lease_out(inout rsp_t r, input int p);
    r.lease_port = p[7:0];
    r.lease_kind = tbl_kind[p];
    r.lease_generation = tbl_gen[p];
    r.lease_owner = tbl_owner[p];
  endfunction

  function automatic void claim_port(input int p, input req_t q, inout rsp_t r);
    if (p >= PORTS || q.kind < 1 || q.kind >= KIND_COUNT || q.owner == 0) begin
      bump(CNT_REJECTED);
      r.status = ST_REJECT;
    end else if (tbl_taken[p]) begin
      if (tbl_kind[p] == q.kind && tbl_owner[p] == q.owner) begin
        r.ok = 1'b1;
        lease_out(r, p);
      end else begin
        bump(CNT_REJECTED);
        r.status = ST_REJECT;
      end
    end else begin
      if (gen_next == 0) gen_next = 1;
      tbl_kind[p] = q.kind;
      tbl_gen[p] = gen_next;
      gen_next = gen_next + 1;
      tbl_owner[p] = q.owner;
      tbl_sample[p] = 33'h1_0000_0000;
      tbl_taken[p] = 1'b1;
      bump(CNT_CLAIMS);
      r.ok = 1'b1;
      lease_out(r, p);
    end
  endfunction

  function automatic bit lease_live(input req_t q);
    if (q.port >= PORTS || !tbl_taken[q.port] || tbl_kind[q.port] != q.kind ||
        tbl_gen[q.port] != q.generation || tbl_owner[q.port] != q.owner) begin
      bump(CNT_STALE);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic rsp_t predict_lease_op(input req_t q);
    rsp_t r;
    int lim;
    int x;
    int y;
    bit done;
    r = '0;
    lim = limit_pred;
    x = $signed(q.stick_x);
    y = $signed(q.stick_y);
    done = 1'b0;
    case (q.operation)
      OP_CLAIM: claim_port(q.port, q, r);
      OP_CLAIM_FREE: begin
        if (q.port >= PORTS) r.status = ST_BADPORT;
        else begin
          for (int i = 0; i < PORTS; i++)
            if (!done && !tbl_taken[(q.port + i) % PORTS]) begin
              claim_port((q.port + i) % PORTS, q, r);
              done = 1'b1;
            end
          if (!done) begin
            bump(CNT_REJECTED);
            r.status = ST_REJECT;
          end
        end
      end
      OP_PUBLISH: begin
        if (!lease_live(q)) r.status = ST_STALE;
        else if (x < -lim || x > lim || y < -lim || y > lim) begin
          bump(CNT_INVALID);
          tbl_sample[q.port] = 33'h1_0000_0000;
          r.status = ST_INVALID;
        end else begin
          tbl_sample[q.port] = q.present ? {1'b1, q.stick_y, q.stick_x, q.buttons} : '0;
          r.ok = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!lease_live(q)) r.status = ST_STALE;
        else begin
          tbl_sample[q.port] = '0;
          tbl_kind[q.port] = '0;
          tbl_gen[q.port] = '0;
          tbl_owner[q.port] = '0;
          tbl_taken[q.port] = 1'b0;
          bump(CNT_RELEASES);
          r.ok = 1'b1;
        end
      end
      OP_READ_SAMP: begin
        if (q.port >= PORTS || !tbl_taken[q.port]) r.status = ST_BADPORT;
        else begin
          r.ok = 1'b1;
          {r.sample_present, r.sample_y, r.sample_x, r.sample_buttons} = tbl_sample[q.port];
        end
      end
      OP_READ_LEASE: begin
        if (q.port >= PORTS || !tbl_taken[q.port]) r.status = ST_BADPORT;
        else begin
          r.ok = 1'b1;
          lease_out(r, q.port);
        end
      end
      OP_READ_CNT: begin
        if (q.port >= N_STATS) r.status = ST_BADPORT;
        else begin
          r.ok = 1'b1;
          r.counter_value = stats[q.port];
        end
      end
      default: r.status = ST_BADPORT;
    endcase
    return r;
  endfunction

  // driver
  int req_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        expected_rsps.push_back(predict_lease_op(req.payload));
      end
      if (!req.valid || req.ready) begin
        if (req_gap > 0) begin
          req_gap <= req_gap - 1;
          req.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          req.payload <= pending_ops.pop_front();
          req.valid <= 1'b1;
          if (!quiet && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 11);
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and response stall
  int rsp_gap = 0;
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) report("unexpected result", 0, 0);
        else begin
          e = expected_rsps.pop_front();
          if (rsp.payload.ok != e.ok) report("ok", rsp.payload.ok, e.ok);
          if (rsp.payload.status != e.status) report("status", rsp.payload.status, e.status);
          if (rsp.payload.lease_port != e.lease_port)
            report("lease_port", rsp.payload.lease_port, e.lease_port);
          if (rsp.payload.lease_kind != e.lease_kind)
            report("lease_kind", rsp.payload.lease_kind, e.lease_kind);
          if (rsp.payload.lease_generation != e.lease_generation)
            report("lease_generation", rsp.payload.lease_generation, e.lease_generation);
          if (rsp.payload.lease_owner != e.lease_owner)
            report("lease_owner", rsp.payload.lease_owner, e.lease_owner);
          if (rsp.payload.sample_buttons != e.sample_buttons)
            report("sample_buttons", rsp.payload.sample_buttons, e.sample_buttons);
          if (rsp.payload.sample_x != e.sample_x)
            report("sample_x", rsp.payload.sample_x, e.sample_x);
          if (rsp.payload.sample_y != e.sample_y)
            report("sample_y", rsp.payload.sample_y, e.sample_y);
          if (rsp.payload.sample_present != e.sample_present)
            report("sample_present", rsp.payload.sample_present, e.sample_present);
          if (rsp.payload.counter_value != e.counter_value)
            report("counter_value", rsp.payload.counter_value, e.counter_value);
        end
      end
      if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) rsp_gap <= $urandom_range(1, 11);
      end
    end
  end

  // random field helpers
  function automatic logic [63:0] rand_owner();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return {$urandom(), $urandom()};
      default: return 64'd1 + $urandom_range(0, 2);
    endcase
  endfunction

  function automatic req_t rand_lease_op();
    req_t q;
    int p;
    q.operation = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 6));
    q.port = $urandom_range(0, 9) == 0 ? 8'($urandom()) : 8'($urandom_range(0, PORTS));
    q.kind = $urandom_range(0, 9) == 0 ? 8'($urandom()) : 8'($urandom_range(1, KIND_COUNT - 1));
    q.owner = rand_owner();
    q.generation = $urandom();
    q.buttons = 16'($urandom());
    q.stick_x = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 60) - 30);
    q.stick_y = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 60) - 30);
    q.present = 1'($urandom());
    // mostly present a live lease for publish and release
    if ((q.operation == OP_PUBLISH || q.operation == OP_RELEASE) && $urandom_range(0, 9) < 8) begin
      p = $urandom_range(0, PORTS - 1);
      if (tbl_shadow_taken[p]) begin
        q.port = 8'(p);
        q.kind = tbl_shadow_kind[p];
        q.owner = tbl_shadow_owner[p];
        q.generation = tbl_shadow_gen[p];
      end
    end
    return q;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || expected_rsps.size() > 0 || req.valid) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    tbl_shadow_taken = tbl_taken;
    tbl_shadow_kind = tbl_kind;
    tbl_shadow_gen = tbl_gen;
    tbl_shadow_owner = tbl_owner;
  endtask

  task automatic write_limit(input logic [6:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_pred = v;
  endtask

  function automatic req_t mk(input logic [2:0] op, input logic [7:0] p, input logic [7:0] k,
                              input logic [63:0] o, input logic [31:0] g);
    req_t q;
    q = '0;
    q.operation = op;
    q.port = p;
    q.kind = k;
    q.owner = o;
    q.generation = g;
    return q;
  endfunction

  initial begin
    req_t q;
    logic [6:0] limits[6];
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    for (int i = 0; i < PORTS; i++) begin
      tbl_taken[i] = 0; tbl_kind[i] = 0; tbl_gen[i] = 0; tbl_owner[i] = 0; tbl_sample[i] = 0;
      tbl_shadow_taken[i] = 0;
    end
    for (int i = 0; i < N_STATS; i++) stats[i] = 0;
    gen_next = 1;
    limit_pred = STICK_LIMIT_RST[6:0];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, claims, idempotent claim, first free, publish, reads, release, counters
    pending_ops.push_back(mk(OP_CLAIM, 0, 0, 5, 0));
    pending_ops.push_back(mk(OP_CLAIM, 0, 8'(KIND_COUNT), 5, 0));
    pending_ops.push_back(mk(OP_CLAIM, 0, 1, 0, 0));
    pending_ops.push_back(mk(OP_CLAIM, 8'hFF, 1, 5, 0));
    pending_ops.push_back(mk(OP_CLAIM, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    pending_ops.push_back(mk(OP_CLAIM, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    pending_ops.push_back(mk(OP_CLAIM, 0, 2, 7, 0));
    pending_ops.push_back(mk(OP_CLAIM_FREE, 8'hFF, 1, 7, 0));
    pending_ops.push_back(mk(OP_CLAIM_FREE, 3, 3, 9, 0));
    pending_ops.push_back(mk(OP_CLAIM_FREE, 3, 2, 9, 0));
    pending_ops.push_back(mk(OP_CLAIM_FREE, 0, 1, 9, 0));
    pending_ops.push_back(mk(OP_CLAIM_FREE, 2, 1, 9, 0));
    q = mk(OP_PUBLISH, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    q.buttons = 16'hFFFF; q.stick_x = 8'd80; q.stick_y = -8'sd80; q.present = 1;
    pending_ops.push_back(q);
    pending_ops.push_back(mk(OP_READ_SAMP, 0, 0, 0, 0));
    q.stick_x = 8'h80;
    pending_ops.push_back(q);
    pending_ops.push_back(mk(OP_READ_SAMP, 0, 0, 0, 0));
    q.stick_x = 0; q.present = 0;
    pending_ops.push_back(q);
    pending_ops.push_back(mk(OP_PUBLISH, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    pending_ops.push_back(mk(OP_READ_LEASE, 1, 0, 0, 0));
    pending_ops.push_back(mk(OP_READ_LEASE, 8'hFF, 0, 0, 0));
    pending_ops.push_back(mk(OP_RELEASE, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1));
    pending_ops.push_back(mk(OP_RELEASE, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1));
    pending_ops.push_back(mk(OP_READ_SAMP, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++) pending_ops.push_back(mk(OP_READ_CNT, 8'(i), 0, 0, 0));
    pending_ops.push_back(mk(3'd7, 0, 1, 1, 1));
    wait_idle();

    limits = '{7'd0, 7'd127, 7'd1, 7'd30, 7'd126, 7'd80};
    foreach (limits[s]) begin
      write_limit(limits[s]);
      if (s == 5) quiet = 1'b1;
      for (int n = 0; n < 85; n++) begin
        // keep the driver queue shallow so live leases track the table
        while (pending_ops.size() > 0 || expected_rsps.size() > 1) @(posedge clk_i);
        tbl_shadow_taken = tbl_taken;
        tbl_shadow_kind = tbl_kind;
        tbl_shadow_gen = tbl_gen;
        tbl_shadow_owner = tbl_owner;
        pending_ops.push_back(rand_lease_op());
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/glpt_pkg.sv
rtl/glpt_req_if.sv
rtl/glpt_rsp_if.sv
rtl/glpt_ctrl.sv
rtl/glpt_datapath.sv
rtl/generation_lease_port_table.sv
dv/tb_generation_lease_port_table.sv
